// ===== rtl/core/abwd_pkg.sv =====
// Shared types, constants and the built-in crypt table for the block word decryptor.
// No dependencies; abwd_step, abwd_keystate and the top level import this package.
`default_nettype none

package abwd_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROM_DEPTH = 256;
    localparam int unsigned ROM_AW    = 8;
    localparam int unsigned ROM_ROWS  = 5;
    localparam int unsigned ROM_ROW   = 4;

    localparam logic [WORD_W-1:0] SEED_INIT = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_ADD   = 32'h1111_1111;
    localparam logic [WORD_W-1:0] SEED_ADD  = 32'd3;
    localparam logic [WORD_W-1:0] GEN_START = 32'h0010_0001;
    localparam logic [WORD_W-1:0] GEN_MOD   = 32'h002A_AAAB;
    localparam logic [WORD_W-1:0] GEN_MUL   = 32'd125;
    localparam logic [WORD_W-1:0] GEN_ADD   = 32'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ROM_DEPTH-1:0][WORD_W-1:0] t_rom;

    // Running cipher state handed between the state registers and the step logic.
    typedef struct packed {
        t_word key;
        t_word seed;
    } t_cipher_state;

    // The generator value stays below 2^22, so the product fits in 32 bits.
    function automatic t_rom build_crypt_rom();
        t_rom        rom;
        t_word       r;
        logic [15:0] hi;
        rom = '0;
        r   = GEN_START;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            for (int j = 0; j < ROM_ROWS; j++) begin
                r  = (r * GEN_MUL + GEN_ADD) % GEN_MOD;
                hi = r[15:0];
                r  = (r * GEN_MUL + GEN_ADD) % GEN_MOD;
                if (j == ROM_ROW) begin
                    rom[i] = {hi, r[15:0]};
                end
            end
        end
        return rom;
    endfunction

    localparam t_rom CRYPT_ROM = build_crypt_rom();

endpackage

`default_nettype wire

// ===== rtl/core/abwd_step.sv =====
// One decryption step: table lookup, unmasking, and the seed and key updates.
// Depends on abwd_pkg for the crypt table and the cipher state type.
`default_nettype none

module abwd_step
    import abwd_pkg::*;
(
    input  wire t_cipher_state i_state,
    input  wire t_word         i_cipher,
    output t_word              o_plain,
    output t_cipher_state      o_state
);

    t_word seed_mix;

    always_comb begin
        seed_mix      = i_state.seed + CRYPT_ROM[i_state.key[ROM_AW-1:0]];
        o_plain       = i_cipher ^ (seed_mix + i_state.key);
        o_state.seed  = seed_mix + o_plain + (seed_mix << 5) + SEED_ADD;
        o_state.key   = ((~i_state.key << 21) + KEY_ADD) | (i_state.key >> 11);
    end

endmodule

`default_nettype wire

// ===== rtl/core/abwd_keystate.sv =====
// Block key register and running key/seed registers with their reload logic.
// Depends on abwd_pkg for the state type and the seed's initial value.
`default_nettype none

module abwd_keystate
    import abwd_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_cfg_we,
    input  wire t_word    i_cfg_wdata,
    input  wire           i_advance,
    input  wire           i_last,
    input  wire t_cipher_state i_next_state,
    output t_cipher_state o_state
);

    t_word         r_block_key;
    t_cipher_state r_state;
    t_cipher_state n_state;

    // A key write reloads from the new key; a finished block reloads from the stored one.
    always_comb begin
        n_state = r_state;
        priority if (i_cfg_we) begin
            n_state.key  = i_cfg_wdata;
            n_state.seed = SEED_INIT;
        end else if (i_advance && i_last) begin
            n_state.key  = r_block_key;
            n_state.seed = SEED_INIT;
        end else if (i_advance) begin
            n_state = i_next_state;
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_key  <= '0;
            r_state.key  <= '0;
            r_state.seed <= SEED_INIT;
        end else begin
            if (i_cfg_we) begin
                r_block_key <= i_cfg_wdata;
            end
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== rtl/core/archive_block_word_decrypt_unit.sv =====
// Top level of the block word decryptor: input register, step logic, result register.
// Depends on abwd_pkg, abwd_keystate and abwd_step.
//
//  channel   direction  handshake            payload
//  i_s_*     in         tvalid/tready        tdata = cipher_word, tlast = last_word
//  o_m_*     out        tvalid/tready        tdata = plain_word,  tlast = last_out
//  i_cfg_*   in         write enable only    wdata = block_key
//
// Input, then result register; one word per cycle sustained unless the output stalls.
// The key/seed step (table read plus adds) is combinational between state registers.
// Reset is synchronous and active low: key 0, seed 0xEEEEEEEE, both stages empty.
// A stalled result register holds its word; the input register still takes one more.
`default_nettype none

module archive_block_word_decrypt_unit
    import abwd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] cipher_word
    input  wire         i_s_tlast,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] plain_word
    output logic        o_m_tlast,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata
);

    logic          r_in_valid;
    t_word         r_in_data;
    logic          r_in_last;
    logic          r_out_valid;
    t_word         r_out_data;
    logic          r_out_last;
    logic          advance;
    t_cipher_state cur_state;
    t_cipher_state step_state;
    t_word         step_plain;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    abwd_keystate u_keystate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_advance    (advance),
        .i_last       (r_in_last),
        .i_next_state (step_state),
        .o_state      (cur_state)
    );

    abwd_step u_step (
        .i_state  (cur_state),
        .i_cipher (r_in_data),
        .o_plain  (step_plain),
        .o_state  (step_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance) begin
            r_out_data <= step_plain;
            r_out_last <= r_in_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/abwd_checker.sv =====
// Port-level checks for the block word decryptor, bound to its top level.
// Depends only on the ports of archive_block_word_decrypt_unit.
`default_nettype none

module abwd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [31:0] o_m_tdata,
    input wire        o_m_tlast
);

    // A stalled result keeps its word and its end-of-block mark.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // With nothing waiting on the output, the input stage must be free.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with an empty output");

    // Every input transaction must reach the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |-> ##2 o_m_tvalid)
        else $error("accepted word did not reach the output");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind archive_block_word_decrypt_unit abwd_checker u_abwd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

// ===== bench/archive_block_word_decrypt_unit_test.sv =====
// Self-checking bench for archive_block_word_decrypt_unit: streams cipher blocks under
// random idling and key loads, and compares every plain word with a local decryptor.
// Depends on abwd_pkg (word type) and the unit itself; reads no files.
`timescale 1ns / 1ps

module archive_block_word_decrypt_unit_test;
    import abwd_pkg::t_word;

    localparam t_word SEED_START  = 32'hEEEE_EEEE;
    localparam t_word KEY_MIX     = 32'h1111_1111;
    localparam t_word TAB_START   = 32'h0010_0001;
    localparam t_word TAB_MOD     = 32'h002A_AAAB;
    localparam t_word TAB_MUL     = 32'd125;
    localparam int    DRAIN_WAIT  = 4;
    localparam int    HOLD_CYCLES = 80;
    localparam int    STALL_LIMIT = 1000;

    typedef struct {
        t_word plain;
        logic  last;
    } t_plain_rec;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [31:0] i_s_tdata   = '0;
    logic        i_s_tlast   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;

    t_word      row_four_tab [256];
    t_word      loaded_key;
    t_word      cur_key;
    t_word      cur_seed;
    t_plain_rec pending_plain_q [$];

    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int words_sent   = 0;
    int blocks_sent  = 0;
    int key_loads    = 0;
    int words_seen   = 0;

    archive_block_word_decrypt_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [31:0] cipher_word
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [31:0] plain_word
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Row four of the crypt table: ten generator steps per index, the last two kept.
    task automatic build_row_four();
        t_word r;
        t_word hi;
        r = TAB_START;
        for (int i = 0; i < 256; i++) begin
            for (int j = 0; j < 5; j++) begin
                r  = (r * TAB_MUL + 32'd3) % TAB_MOD;
                hi = r & 32'h0000_FFFF;
                r  = (r * TAB_MUL + 32'd3) % TAB_MOD;
                if (j == 4) begin
                    row_four_tab[i] = (hi << 16) | (r & 32'h0000_FFFF);
                end
            end
        end
    endtask

    function automatic void restart_stream();
        cur_key  = loaded_key;
        cur_seed = SEED_START;
    endfunction

    function automatic void predict_plain(input t_word cw, input logic last);
        t_word      seed;
        t_plain_rec rec;
        seed      = cur_seed + row_four_tab[cur_key[7:0]];
        rec.plain = cw ^ (seed + cur_key);
        rec.last  = last;
        seed      = seed + rec.plain + (seed << 5) + 32'd3;
        cur_key   = (((~cur_key) << 21) + KEY_MIX) | (cur_key >> 11);
        cur_seed  = seed;
        if (last) begin
            restart_stream();
        end
        pending_plain_q.push_back(rec);
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatches++;
        $display("%0t: %s mismatch, got %08h, expected %08h", $realtime, what, got, want);
    endtask

    // One input transaction, with an optional idle burst in front of it.
    task automatic send_word(input t_word cw, input logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= cw;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_plain(cw, last);
        words_sent++;
        if (last) begin
            blocks_sent++;
        end
    endtask

    // Stop offering words and wait until every predicted word has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_plain_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_key(input t_word k);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        loaded_key = k;
        restart_stream();
        key_loads++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_word pick_key();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return {$urandom_range(0, 255) == 0 ? 24'h0 : 24'($urandom), 8'hFF};
            default: return $urandom;
        endcase
    endfunction

    // A block of random words; now and then the key is reloaded part way through.
    task automatic send_block(input int len, input bit allow_break);
        int cut;
        cut = (allow_break && len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1)
                                                                     : -1;
        for (int i = 0; i < len; i++) begin
            if (i == cut) begin
                load_key(pick_key());
            end
            send_word($urandom, i == len - 1);
        end
    endtask

    task automatic test_reset_key();
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h5555_5555, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_key_extremes();
        load_key(32'hFFFF_FFFF);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        load_key(32'h0000_0000);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h8765_4321, 1'b1);
        load_key(32'h8000_00FF);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        // Reload in the middle of a block: the rest continues from a fresh stream.
        load_key(32'h7FFF_FF00);
        send_word(32'hDEAD_BEEF, 1'b0);
        send_word(32'h0F0F_0F0F, 1'b0);
        load_key(32'h0000_0001);
        send_word(32'hF0F0_F0F0, 1'b0);
        send_word(32'hCAFE_F00D, 1'b1);
    endtask

    task automatic test_random_blocks(input int words);
        int stop_at;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                load_key(pick_key());
            end
            send_block(($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                      : $urandom_range(1, 16), 1'b1);
        end
    endtask

    // The receiver holds off while words keep coming, so the input side stalls.
    task automatic test_backpressure();
        wait_drained();
        @(negedge i_clk);
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_word($urandom, ($urandom_range(0, 7) == 0) || i == 39);
        end
        wait_drained();
    endtask

    task automatic test_full_rate(input int words);
        idle_on = 1'b0;
        load_key(pick_key());
        test_random_blocks(words);
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_plain_rec want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            words_seen++;
            if (pending_plain_q.size() == 0) begin
                report_mismatch("unexpected word", o_m_tdata, 32'h0);
            end else begin
                want = pending_plain_q.pop_front();
                if (o_m_tdata !== want.plain) begin
                    report_mismatch("plain_word", o_m_tdata, want.plain);
                end
                if (o_m_tlast !== want.last) begin
                    report_mismatch("last_out", 32'(o_m_tlast), 32'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        build_row_four();
        loaded_key = 32'h0;
        restart_stream();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_key();
        test_key_extremes();
        test_random_blocks(400);
        test_backpressure();
        test_random_blocks(250);
        test_full_rate(150);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (pending_plain_q.size() != 0) begin
            report_mismatch("missing words", 32'(pending_plain_q.size()), 32'h0);
        end
        $display("sent %0d words in %0d blocks with %0d key loads; %0d words checked",
                 words_sent, blocks_sent, key_loads, words_seen);
        $display("covered random idling on both sides, a long output stall and full rate");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/abwd_pkg.sv
rtl/core/abwd_step.sv
rtl/core/abwd_keystate.sv
rtl/core/archive_block_word_decrypt_unit.sv
rtl/core/abwd_checker.sv
bench/archive_block_word_decrypt_unit_test.sv
